@@ sv/spt_pkg.sv @@
// Shared types and constants of the sparse polynomial term table.
`timescale 1ns / 1ps

package spt_pkg;

    localparam int MAX_TERMS = 64;
    localparam int MAX_POWER = 63;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int PWR_W     = 6;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_EVAL   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_SLOT   = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] coef;
        logic [PWR_W-1:0]   power;
        logic signed [31:0] x_value;
        logic [5:0]         slot;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] value;
        logic signed [31:0] read_coef;
        logic [PWR_W-1:0]   read_power;
        logic [6:0]         term_count;
        t_status            status;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic [PWR_W-1:0]   power;
        logic signed [31:0] coef;
    } t_term;

    // Datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CFG,
        DP_RD_IDX,
        DP_SCAN_NEXT,
        DP_MERGE,
        DP_WRITE_MERGED,
        DP_DEL_RD,
        DP_DEL_WR,
        DP_DEL_DONE,
        DP_INS_INIT,
        DP_INS_RD,
        DP_INS_WR,
        DP_INS_PUT,
        DP_RD_SLOT,
        DP_RD_OUT,
        DP_EV_START,
        DP_MUL_X,
        DP_EV_POW,
        DP_MUL_C,
        DP_EV_ACC,
        DP_REV_RD,
        DP_REV_WR1,
        DP_REV_WR2,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    set_status;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic coef_zero;
        logic power_ok;
        logic scan_end;
        logic hit;
        logic precedes;
        logic full;
        logic sum_zero;
        logic del_more;
        logic ins_more;
        logic slot_ok;
        logic rev_more;
        logic k_more;
        logic rev_need;
        logic out_free;
    } t_dp_stat;

endpackage

@@ sv/spt_ctrl.sv @@
// Controller state machine of the sparse polynomial term table.
`timescale 1ns / 1ps

module spt_ctrl import spt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_cfg_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_cfg_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_CHK,
        S_SCAN_CMP,
        S_MERGE,
        S_MERGE_CHK,
        S_DEL_CHK,
        S_DEL_WR,
        S_INS_CHK,
        S_INS_WR,
        S_RD_OUT,
        S_EV_CHK,
        S_EV_TERM,
        S_EV_POWCHK,
        S_EV_POW,
        S_EV_ACC,
        S_REV_CHK,
        S_REV_WR1,
        S_REV_WR2,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   v_miss;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;

    // Next state and datapath command
    always_comb begin
        n_state          = r_state;
        o_cmd.op         = DP_NOP;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = ST_OK;
        v_miss           = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end else if (i_cfg_valid) begin
                    o_cmd.op = DP_CFG;
                    n_state  = i_stat.rev_need ? S_REV_CHK : S_IDLE;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.cmd)
                    CMD_ADD: begin
                        if (i_stat.coef_zero) begin
                            n_state = S_FINISH;
                        end else if (!i_stat.power_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_ABSENT;
                            n_state          = S_FINISH;
                        end else begin
                            n_state = S_SCAN_CHK;
                        end
                    end
                    CMD_REMOVE: n_state = S_SCAN_CHK;
                    CMD_EVAL:   n_state = S_EV_CHK;
                    CMD_READ: begin
                        if (i_stat.slot_ok) begin
                            o_cmd.op = DP_RD_SLOT;
                            n_state  = S_RD_OUT;
                        end else begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_SLOT;
                            n_state          = S_FINISH;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_SCAN_CHK: begin
                if (i_stat.scan_end) begin
                    v_miss = 1'b1;
                end else begin
                    o_cmd.op = DP_RD_IDX;
                    n_state  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.hit) begin
                    n_state = (i_stat.cmd == CMD_ADD) ? S_MERGE : S_DEL_CHK;
                end else if (!i_stat.precedes) begin
                    v_miss = 1'b1;
                end else begin
                    o_cmd.op = DP_SCAN_NEXT;
                    n_state  = S_SCAN_CHK;
                end
            end
            S_MERGE: begin
                o_cmd.op = DP_MERGE;
                n_state  = S_MERGE_CHK;
            end
            S_MERGE_CHK: begin
                if (i_stat.sum_zero) begin
                    n_state = S_DEL_CHK;
                end else begin
                    o_cmd.op = DP_WRITE_MERGED;
                    n_state  = S_FINISH;
                end
            end
            S_DEL_CHK: begin
                if (i_stat.del_more) begin
                    o_cmd.op = DP_DEL_RD;
                    n_state  = S_DEL_WR;
                end else begin
                    o_cmd.op = DP_DEL_DONE;
                    n_state  = S_FINISH;
                end
            end
            S_DEL_WR: begin
                o_cmd.op = DP_DEL_WR;
                n_state  = S_DEL_CHK;
            end
            S_INS_CHK: begin
                if (i_stat.ins_more) begin
                    o_cmd.op = DP_INS_RD;
                    n_state  = S_INS_WR;
                end else begin
                    o_cmd.op = DP_INS_PUT;
                    n_state  = S_FINISH;
                end
            end
            S_INS_WR: begin
                o_cmd.op = DP_INS_WR;
                n_state  = S_INS_CHK;
            end
            S_RD_OUT: begin
                o_cmd.op = DP_RD_OUT;
                n_state  = S_FINISH;
            end
            S_EV_CHK: begin
                if (i_stat.scan_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = DP_RD_IDX;
                    n_state  = S_EV_TERM;
                end
            end
            S_EV_TERM: begin
                o_cmd.op = DP_EV_START;
                n_state  = S_EV_POWCHK;
            end
            S_EV_POWCHK: begin
                if (i_stat.k_more) begin
                    o_cmd.op = DP_MUL_X;
                    n_state  = S_EV_POW;
                end else begin
                    o_cmd.op = DP_MUL_C;
                    n_state  = S_EV_ACC;
                end
            end
            S_EV_POW: begin
                o_cmd.op = DP_EV_POW;
                n_state  = S_EV_POWCHK;
            end
            S_EV_ACC: begin
                o_cmd.op = DP_EV_ACC;
                n_state  = S_EV_CHK;
            end
            S_REV_CHK: begin
                if (i_stat.rev_more) begin
                    o_cmd.op = DP_REV_RD;
                    n_state  = S_REV_WR1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REV_WR1: begin
                o_cmd.op = DP_REV_WR1;
                n_state  = S_REV_WR2;
            end
            S_REV_WR2: begin
                o_cmd.op = DP_REV_WR2;
                n_state  = S_REV_CHK;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Power not in the table: insert on add (or report full if the table is full), report absent on remove
        if (v_miss) begin
            if (i_stat.cmd == CMD_ADD) begin
                if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.op = DP_INS_INIT;
                    n_state  = S_INS_CHK;
                end
            end else begin
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_ABSENT;
                n_state          = S_FINISH;
            end
        end
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/spt_dp.sv @@
// Datapath of the sparse polynomial term table: term memory, multiplier, accumulator.
`timescale 1ns / 1ps

module spt_dp import spt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_cfg_data,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_stall,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    t_term               r_mem [MAX_TERMS];
    t_term               r_rd_a;
    t_term               r_rd_b;
    t_in_item            r_item;
    logic [CNT_W-1:0]    r_count;
    logic                r_sort;
    logic [CNT_W-1:0]    r_idx;
    logic [ADDR_W-1:0]   r_j;
    logic [PWR_W-1:0]    r_k;
    logic signed [31:0]  r_pw;
    logic signed [63:0]  r_prod;
    logic signed [47:0]  r_acc;
    logic signed [31:0]  r_sum;
    logic                r_sat;
    t_status             r_status;
    logic signed [31:0]  r_rcoef;
    logic [PWR_W-1:0]    r_rpower;
    logic                r_out_valid;
    t_out_item           r_out;

    logic signed [31:0]  w_mul_a;
    logic signed [31:0]  w_mul_b;
    logic signed [63:0]  w_prod;
    logic signed [63:0]  w_rnd_t;
    logic signed [47:0]  w_rnd;
    logic signed [31:0]  w_pw_next;
    logic                w_pw_sat;
    logic signed [48:0]  w_acc_sum;
    logic signed [47:0]  w_acc_next;
    logic                w_acc_sat;
    logic signed [32:0]  w_m_sum;
    logic signed [31:0]  w_m_next;
    logic                w_m_sat;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    t_term               w_wdata;
    logic                w_re_a;
    logic [ADDR_W-1:0]   w_raddr_a;

    // Share one multiplier between x^p and coef * x^p
    assign w_mul_a = (i_cmd.op == DP_MUL_C) ? r_rd_a.coef : r_pw;
    assign w_mul_b = (i_cmd.op == DP_MUL_C) ? r_pw : r_item.x_value;
    assign w_prod  = w_mul_a * w_mul_b;

    // Round the registered product to Q.16 to nearest, halves rounded up
    assign w_rnd_t = r_prod + 64'sd32768;
    assign w_rnd   = w_rnd_t[63:16];

    // Saturate power term to 32 bits
    always_comb begin
        w_pw_sat  = (w_rnd[47:31] != {17{w_rnd[47]}});
        w_pw_next = w_rnd[31:0];
        if (w_pw_sat) begin
            w_pw_next = w_rnd[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Saturate running sum to 48 bits
    always_comb begin
        w_acc_sum  = {r_acc[47], r_acc} + {w_rnd[47], w_rnd};
        w_acc_sat  = (w_acc_sum[48] != w_acc_sum[47]);
        w_acc_next = w_acc_sum[47:0];
        if (w_acc_sat) begin
            w_acc_next = w_acc_sum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
    end

    // Saturate merged coefficient to 32 bits
    always_comb begin
        w_m_sum  = {r_rd_a.coef[31], r_rd_a.coef} + {r_item.coef[31], r_item.coef};
        w_m_sat  = (w_m_sum[32] != w_m_sum[31]);
        w_m_next = w_m_sum[31:0];
        if (w_m_sat) begin
            w_m_next = w_m_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Select memory write and read addresses
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_idx[ADDR_W-1:0];
        w_wdata   = r_rd_a;
        w_re_a    = 1'b0;
        w_raddr_a = r_idx[ADDR_W-1:0];
        case (i_cmd.op)
            DP_RD_IDX, DP_REV_RD: begin
                w_re_a = 1'b1;
            end
            DP_DEL_RD: begin
                w_re_a    = 1'b1;
                w_raddr_a = r_idx[ADDR_W-1:0] + 1'b1;
            end
            DP_INS_RD: begin
                w_re_a    = 1'b1;
                w_raddr_a = r_j - 1'b1;
            end
            DP_RD_SLOT: begin
                w_re_a    = 1'b1;
                w_raddr_a = r_item.slot[ADDR_W-1:0];
            end
            DP_WRITE_MERGED: begin
                w_we         = 1'b1;
                w_wdata.coef = r_sum;
            end
            DP_DEL_WR, DP_REV_WR2: begin
                w_we    = 1'b1;
                w_waddr = (i_cmd.op == DP_REV_WR2) ? r_j : r_idx[ADDR_W-1:0];
            end
            DP_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j;
            end
            DP_INS_PUT: begin
                w_we          = 1'b1;
                w_wdata.power = r_item.power;
                w_wdata.coef  = r_item.coef;
            end
            DP_REV_WR1: begin
                w_we    = 1'b1;
                w_wdata = r_rd_b;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Term memory with registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re_a) begin
            r_rd_a <= r_mem[w_raddr_a];
        end
        if (i_cmd.op == DP_REV_RD) begin
            r_rd_b <= r_mem[r_j];
        end
    end

    // Hold term count, order bit and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sort      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_DEL_DONE) begin
                r_count <= r_count - 1'b1;
            end else if (i_cmd.op == DP_INS_PUT) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.op == DP_CFG) begin
                r_sort <= i_cfg_data;
            end
            if (i_cmd.op == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Advance working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_item   <= i_in_item;
                r_idx    <= '0;
                r_acc    <= '0;
                r_sat    <= 1'b0;
                r_rcoef  <= '0;
                r_rpower <= '0;
                r_status <= ST_OK;
            end
            DP_CFG: begin
                r_idx <= '0;
                r_j   <= r_count[ADDR_W-1:0] - 1'b1;
            end
            DP_SCAN_NEXT, DP_DEL_WR: begin
                r_idx <= r_idx + 1'b1;
            end
            DP_MERGE: begin
                r_sum <= w_m_next;
                r_sat <= r_sat | w_m_sat;
            end
            DP_INS_INIT: begin
                r_j <= r_count[ADDR_W-1:0];
            end
            DP_INS_WR: begin
                r_j <= r_j - 1'b1;
            end
            DP_RD_OUT: begin
                r_rcoef  <= r_rd_a.coef;
                r_rpower <= r_rd_a.power;
            end
            DP_EV_START: begin
                r_pw <= Q_ONE;
                r_k  <= '0;
            end
            DP_MUL_X, DP_MUL_C: begin
                r_prod <= w_prod;
            end
            DP_EV_POW: begin
                r_pw  <= w_pw_next;
                r_k   <= r_k + 1'b1;
                r_sat <= r_sat | w_pw_sat;
            end
            DP_EV_ACC: begin
                r_acc <= w_acc_next;
                r_sat <= r_sat | w_acc_sat;
                r_idx <= r_idx + 1'b1;
            end
            DP_REV_WR2: begin
                r_idx <= r_idx + 1'b1;
                r_j   <= r_j - 1'b1;
            end
            DP_EMIT: begin
                r_out.value      <= r_acc;
                r_out.read_coef  <= r_rcoef;
                r_out.read_power <= r_rpower;
                r_out.term_count <= r_count;
                r_out.status     <= r_status;
                r_out.overflow   <= r_sat;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    // Report conditions to the controller
    always_comb begin
        o_stat.cmd       = r_item.command;
        o_stat.coef_zero = (r_item.coef == 32'sd0);
        o_stat.power_ok  = ({2'b00, r_item.power} <= 8'(MAX_POWER));
        o_stat.scan_end  = (r_idx == r_count);
        o_stat.hit       = (r_rd_a.power == r_item.power);
        o_stat.precedes  = r_sort ? (r_rd_a.power < r_item.power)
                                  : (r_rd_a.power > r_item.power);
        o_stat.full      = (r_count == CNT_W'(MAX_TERMS));
        o_stat.sum_zero  = (r_sum == 32'sd0);
        o_stat.del_more  = ((r_idx + 1'b1) < r_count);
        o_stat.ins_more  = ({1'b0, r_j} > r_idx);
        o_stat.slot_ok   = ({1'b0, r_item.slot} < r_count);
        o_stat.rev_more  = (r_idx < {1'b0, r_j});
        o_stat.k_more    = (r_k < r_rd_a.power);
        o_stat.rev_need  = (i_cfg_data != r_sort) && (r_count > CNT_W'(1));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ sv/sparse_polynomial_term_table.sv @@
// Top level of the sparse polynomial term table.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_stall      i_in_item  (t_in_item)
//   output    out        o_out_valid / i_out_stall    o_out_item (t_out_item)
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (sort_ascending)
//
// One item at a time; the term memory has one write port, so every moved entry
// takes a read and then a write. Add/remove scan the terms in order, then shift
// the entries behind the hit or insertion point. Evaluate raises x to each power
// through the shared multiplier. Order change reverses the table pair by pair.
// Reset is synchronous and empties the table; term memory itself is not cleared.
// A result held by i_out_stall parks the next item in its finish state, so the
// block takes no further item until the held result leaves.
`timescale 1ns / 1ps

module sparse_polynomial_term_table import spt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    spt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    spt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a previous item is in work");

    a_cfg_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_in_stall)
        else $error("config port ready while an item is in work");

    a_slot_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_SLOT)) |->
        ((o_out_item.read_coef == 32'sd0) && (o_out_item.read_power == '0)))
        else $error("bad slot read returned term data");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_FULL)) |->
        (o_out_item.term_count == 7'(MAX_TERMS)))
        else $error("table full reported below capacity");
`endif

endmodule

@@ dv/tb_sparse_polynomial_term_table.sv @@
// Self-checking testbench of the sparse polynomial term table.
`timescale 1ns / 1ps

module tb_sparse_polynomial_term_table;
    import spt_pkg::*;

    localparam int N_RANDOM  = 500;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint S48_HI = 64'sd140737488355327;
    localparam longint S48_LO = -64'sd140737488355328;
    localparam int CYCLE_LIMIT = 20000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;

    sparse_polynomial_term_table dut (.*);

    always #5 i_clk = ~i_clk;

    // Predicted table contents and order
    logic signed [31:0] tbl_coef [MAX_TERMS];
    logic [5:0]         tbl_power [MAX_TERMS];
    int                 tbl_count = 0;
    logic               order_up = 1'b0;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int  error_count = 0;
    int  result_count = 0;
    int  eval_count = 0;
    longint cycle_count = 0;

    function automatic longint round_q16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint sat_range(longint v, longint lo, longint hi, ref bit sat);
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic int find_term(logic [5:0] p);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_power[i] == p) return i;
        return -1;
    endfunction

    function automatic void drop_term(int idx);
        for (int i = idx; i + 1 < tbl_count; i++) begin
            tbl_coef[i]  = tbl_coef[i + 1];
            tbl_power[i] = tbl_power[i + 1];
        end
        tbl_count--;
    endfunction

    // Apply a new sort order: reverse the table when the order flips
    function automatic void apply_order(logic up);
        logic signed [31:0] c;
        logic [5:0] p;
        if (up != order_up) begin
            for (int i = 0, j = tbl_count - 1; i < j; i++, j--) begin
                c = tbl_coef[i]; p = tbl_power[i];
                tbl_coef[i] = tbl_coef[j]; tbl_power[i] = tbl_power[j];
                tbl_coef[j] = c; tbl_power[j] = p;
            end
        end
        order_up = up;
    endfunction

    // Work out the result of one item and update the predicted table
    function automatic t_out_item term_table_step(t_in_item it);
        t_out_item r;
        bit sat;
        int f, pos;
        longint s, acc, pw;
        r = '0;
        r.status = ST_OK;
        sat = 1'b0;
        case (it.command)
            CMD_ADD: begin
                if (it.coef != 0) begin
                    f = find_term(it.power);
                    if (f >= 0) begin
                        s = sat_range(longint'(tbl_coef[f]) + longint'(it.coef),
                                      S32_LO, S32_HI, sat);
                        if (s == 0) drop_term(f);
                        else tbl_coef[f] = s[31:0];
                    end else if (tbl_count >= MAX_TERMS) begin
                        r.status = ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < tbl_count && (order_up ? tbl_power[pos] < it.power
                                                            : tbl_power[pos] > it.power))
                            pos++;
                        for (int i = tbl_count; i > pos; i--) begin
                            tbl_coef[i]  = tbl_coef[i - 1];
                            tbl_power[i] = tbl_power[i - 1];
                        end
                        tbl_coef[pos]  = it.coef;
                        tbl_power[pos] = it.power;
                        tbl_count++;
                    end
                end
            end
            CMD_REMOVE: begin
                f = find_term(it.power);
                if (f >= 0) drop_term(f);
                else r.status = ST_ABSENT;
            end
            CMD_EVAL: begin
                acc = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    pw = 65536;
                    for (int k = 0; k < tbl_power[i]; k++)
                        pw = sat_range(round_q16(pw * longint'(it.x_value)),
                                       S32_LO, S32_HI, sat);
                    acc = sat_range(acc + round_q16(longint'(tbl_coef[i]) * pw),
                                    S48_LO, S48_HI, sat);
                end
                r.value = acc[47:0];
            end
            default: begin
                if (it.slot < tbl_count) begin
                    r.read_coef  = tbl_coef[it.slot];
                    r.read_power = tbl_power[it.slot];
                end else begin
                    r.status = ST_SLOT;
                end
            end
        endcase
        r.term_count = tbl_count[6:0];
        r.overflow = sat;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // Feed pending items; predict each one as it is accepted
    int  send_gap = 0;
    bit  driving_on = 1'b0;
    bit  in_taken = 1'b0;
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            expected_results.push_back(term_table_step(i_in_item));
            in_taken = 1'b1;
        end
    end
    always @(negedge i_clk) begin
        if (in_taken) begin
            in_taken = 1'b0;
            void'(pending_items.pop_front());
            i_in_valid <= 1'b0;
        end else if (i_in_valid) begin
            // hold the stalled item
        end else if (send_gap > 0) begin
            send_gap--;
        end else if (driving_on && pending_items.size() != 0) begin
            i_in_item  <= pending_items[0];
            i_in_valid <= 1'b1;
            send_gap = gap_len();
        end
    end

    // Check each result against the oldest expectation
    int stall_left = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (o_out_valid && !i_out_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                t_out_item e;
                e = expected_results.pop_front();
                if (o_out_item.value !== e.value) begin
                    $error("value exp %0d got %0d", e.value, o_out_item.value);
                    error_count++;
                end
                if (o_out_item.read_coef !== e.read_coef) begin
                    $error("read_coef exp %0d got %0d", e.read_coef, o_out_item.read_coef);
                    error_count++;
                end
                if (o_out_item.read_power !== e.read_power) begin
                    $error("read_power exp %0d got %0d", e.read_power, o_out_item.read_power);
                    error_count++;
                end
                if (o_out_item.term_count !== e.term_count) begin
                    $error("term_count exp %0d got %0d", e.term_count, o_out_item.term_count);
                    error_count++;
                end
                if (o_out_item.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out_item.status);
                    error_count++;
                end
                if (o_out_item.overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, o_out_item.overflow);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Random output stall
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = gap_len();
            i_out_stall <= (stall_left != 0);
        end
    end

    function automatic t_in_item make_item(t_cmd c, logic signed [31:0] cf, logic [5:0] p,
                                           logic signed [31:0] x, logic [5:0] s);
        t_in_item it;
        it.command = c; it.coef = cf; it.power = p; it.x_value = x; it.slot = s;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_cmd c;
        logic [5:0] p;
        logic [5:0] s;
        c = t_cmd'($urandom_range(0, 3));
        p = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
        s = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 8));
        return make_item(c, rand_word(), p,
                         ($urandom_range(0, 2) == 0) ? rand_word()
                                                     : $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000,
                         s);
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_order(logic up);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= up;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_order(up);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        repeat (300) @(posedge i_clk);
    endtask

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        driving_on = 1'b1;

        // Directed: extremes, every command, each special case
        pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_EVAL, 0, 0, 32'sh7fffffff, 0));
        pending_items.push_back(make_item(CMD_ADD, 0, 5, 0, 0));
        pending_items.push_back(make_item(CMD_ADD, 32'sh7fffffff, 63, 0, 63));
        pending_items.push_back(make_item(CMD_ADD, 32'sh7fffffff, 63, 0, 0));
        pending_items.push_back(make_item(CMD_ADD, 32'sh80000000, 0, 0, 0));
        pending_items.push_back(make_item(CMD_ADD, 32'sh00010000, 1, 0, 0));
        pending_items.push_back(make_item(CMD_ADD, -32'sh00010000, 1, 0, 0));
        pending_items.push_back(make_item(CMD_ADD, 32'sh00030000, 2, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE, 0, 9, 0, 0));
        pending_items.push_back(make_item(CMD_EVAL, 0, 0, 32'sh7fffffff, 0));
        pending_items.push_back(make_item(CMD_EVAL, 0, 0, 32'sh80000000, 0));
        pending_items.push_back(make_item(CMD_EVAL, 0, 0, 32'sh00018000, 0));
        pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 1));
        pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 2));
        pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 3));
        pending_items.push_back(make_item(CMD_REMOVE, 0, 63, 0, 0));
        wait_drained();
        write_order(1'b1);
        pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0));
        // Add every power to the table, then add once more to power 7
        for (int p = 0; p < 64; p++)
            pending_items.push_back(make_item(CMD_ADD, $urandom() | 1, p[5:0], 0, 0));
        pending_items.push_back(make_item(CMD_ADD, 32'sh00010000, 7, 0, 63));
        pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 63));
        pending_items.push_back(make_item(CMD_EVAL, 0, 0, 32'sh0000ff00, 0));
        wait_drained();
        write_order(1'b0);
        pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_REMOVE, 0, 10, 0, 0));
        pending_items.push_back(make_item(CMD_ADD, 32'sh00010000, 10, 0, 0));
        wait_drained();
        write_order(1'b0);
        for (int p = 0; p < 64; p++)
            pending_items.push_back(make_item(CMD_REMOVE, 0, p[5:0], 0, 0));
        wait_drained();

        // Random phases across both orders
        run_phase(N_RANDOM / 4);
        write_order(1'b1);
        run_phase(N_RANDOM / 4);
        write_order(1'b0);
        run_phase(N_RANDOM / 4);
        write_order(1'b1);
        run_phase(N_RANDOM / 4);

        $display("covered %0d results over add, remove, evaluate and read,", result_count);
        $display("with full and empty table and both sort orders");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
